// ----- design/bmro_pkg.sv -----
package bmro_pkg;

  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // Request kinds
  localparam logic [2:0] REQ_RD_BYTE  = 3'd0;
  localparam logic [2:0] REQ_RD_WORD  = 3'd1;
  localparam logic [2:0] REQ_WR_BYTE  = 3'd2;
  localparam logic [2:0] REQ_WR_WORD  = 3'd3;
  localparam logic [2:0] REQ_DBG_BYTE = 3'd4;
  localparam logic [2:0] REQ_DBG_WORD = 3'd5;
  localparam logic [2:0] REQ_SEL_BANK = 3'd6;

  // Bank modes
  localparam logic [1:0] MODE_BANK0    = 2'd0;
  localparam logic [1:0] MODE_EXPLICIT = 2'd1;
  localparam logic [1:0] MODE_CURRENT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ROM_ENABLED = 3'd0;
  localparam logic [2:0] CFG_ROM_START   = 3'd1;
  localparam logic [2:0] CFG_ROM_SIZE    = 3'd2;
  localparam logic [2:0] CFG_MAIN_SIZE   = 3'd3;
  localparam logic [2:0] CFG_BANK_COUNT  = 3'd4;

  typedef struct packed {
    logic        rom_enabled;
    logic [15:0] rom_start;
    logic [16:0] rom_size;
    logic [16:0] main_size;
    logic [3:0]  bank_count;
  } cfg_t;

  // Decoded access, one per accepted word.
  typedef struct packed {
    logic       err;
    logic       rd;       // successful read
    logic       rd_rom;   // read served by the ROM
    logic       wr_ram;
    logic       wr_rom;
    logic       word;
    logic       odd;
    logic       sel_bank; // successful bank selection
    logic [3:0] tgt_bank;
  } cmd_t;

endpackage

// ----- design/bmro_lane_mem.sv -----
module bmro_lane_mem #(
  parameter int DEPTH = 2,
  parameter int IDX_W = 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [IDX_W-1:0]          idx,
  input  logic [bmro_pkg::BYTE_W-1:0] wdata,
  output logic [bmro_pkg::BYTE_W-1:0] rdata
);

  logic [bmro_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    if (re) begin
      rdata <= mem[idx];
    end
  end

endmodule

// ----- design/bmro_decode.sv -----
module bmro_decode #(
  parameter int ADDR_BITS = 16,
  parameter int NUM_BANKS = 16
) (
  input  bmro_pkg::cfg_t cfg,
  input  logic [3:0]     cur_bank,
  input  logic [2:0]     req_type,
  input  logic [1:0]     bank_mode,
  input  logic [3:0]     bank,
  input  logic [15:0]    addr,
  output bmro_pkg::cmd_t cmd
);

  localparam logic [16:0] SPAN = 17'(1) << ADDR_BITS;
  localparam logic [4:0]  NB   = 5'(NUM_BANKS);

  logic        word;
  logic [16:0] last;
  logic [16:0] ram_limit;
  logic [17:0] rom_end;
  logic        span_err;
  logic        below_limit;
  logic        rom_hit;
  logic        bank_ok;
  logic        b0_rom;
  logic        b0_ram;

  always_comb begin
    word        = req_type[0];
    last        = {1'b0, addr} + 17'(word);
    ram_limit   = (cfg.main_size < SPAN) ? cfg.main_size : SPAN;
    rom_end     = {2'b00, cfg.rom_start} + {1'b0, cfg.rom_size};
    span_err    = last >= SPAN;
    below_limit = last < ram_limit;
    rom_hit     = cfg.rom_enabled && (addr >= cfg.rom_start) && ({1'b0, last} < rom_end);
    bank_ok     = ({1'b0, bank} < {1'b0, cfg.bank_count}) && ({1'b0, bank} < NB);
    // Bank zero read: ROM window first, then RAM below the limit.
    b0_rom      = !span_err && rom_hit;
    b0_ram      = !span_err && !rom_hit && below_limit;

    cmd          = '0;
    cmd.word     = word;
    cmd.odd      = addr[0];
    cmd.tgt_bank = 4'd0;

    case (req_type)
      bmro_pkg::REQ_RD_BYTE, bmro_pkg::REQ_RD_WORD: begin
        case (bank_mode)
          bmro_pkg::MODE_BANK0: begin
            cmd.rd     = b0_rom || b0_ram;
            cmd.rd_rom = b0_rom;
          end
          bmro_pkg::MODE_EXPLICIT: begin
            if (bank == 4'd0) begin
              cmd.rd     = b0_rom || b0_ram;
              cmd.rd_rom = b0_rom;
            end else begin
              cmd.rd       = bank_ok && !span_err;
              cmd.tgt_bank = bank;
            end
          end
          bmro_pkg::MODE_CURRENT: begin
            if (cur_bank == 4'd0) begin
              cmd.rd     = b0_rom || b0_ram;
              cmd.rd_rom = b0_rom;
            end else begin
              cmd.rd       = !span_err;
              cmd.tgt_bank = cur_bank;
            end
          end
          default: cmd.rd = 1'b0;
        endcase
        cmd.err = !cmd.rd;
      end
      bmro_pkg::REQ_WR_BYTE, bmro_pkg::REQ_WR_WORD: begin
        case (bank_mode)
          bmro_pkg::MODE_BANK0: begin
            cmd.wr_ram = below_limit;
          end
          bmro_pkg::MODE_EXPLICIT: begin
            cmd.wr_ram   = below_limit && bank_ok;
            cmd.tgt_bank = bank;
          end
          bmro_pkg::MODE_CURRENT: begin
            cmd.wr_ram   = below_limit;
            cmd.tgt_bank = cur_bank;
          end
          default: cmd.wr_ram = 1'b0;
        endcase
        cmd.err = !cmd.wr_ram;
      end
      bmro_pkg::REQ_DBG_BYTE, bmro_pkg::REQ_DBG_WORD: begin
        cmd.wr_rom = b0_rom;
        cmd.wr_ram = b0_ram;
        cmd.err    = !(b0_rom || b0_ram);
      end
      bmro_pkg::REQ_SEL_BANK: begin
        cmd.sel_bank = bank_ok;
        cmd.tgt_bank = bank;
        cmd.err      = !bank_ok;
      end
      default: cmd.err = 1'b1;
    endcase
  end

endmodule

// ----- design/banked_memory_rom_overlay.sv -----
// Channel  Direction  Ports                         Contents
// in       slave      in_tvalid/in_tready           tuser: req_type, bank_mode
//                     in_tdata, in_tuser            tdata: bank, addr, wdata
// out      master     out_tvalid/out_tready         tdata: rdata, active_bank
//                     out_tdata, out_tuser          tuser: error
// cfg      slave      cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One access is taken per cycle while the output drains and no clearing pass runs; the
// result passes through the read stage, where the byte-lane memories give their data, then the output register.
// After reset a clearing pass zeroes RAM and ROM, one row of both lanes per cycle, over all
// NUM_BANKS * 2^(ADDR_BITS-1) RAM rows (524288 at the defaults); no access is taken then.
// A stalled result holds in the output register while one more access may enter the
// read stage; the input then stalls until the output drains.
module banked_memory_rom_overlay #(
  parameter int ADDR_BITS = 16,
  parameter int NUM_BANKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // bank[3:0], addr[19:4], wdata[35:20], zero fill
  input  logic [4:0]  in_tuser,   // req_type[2:0], bank_mode[4:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // rdata[15:0], active_bank[19:16], zero fill
  output logic [0:0]  out_tuser,  // error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int BW       = bmro_pkg::BYTE_W;
  localparam int HALF_W   = ADDR_BITS - 1;
  localparam int ROM_ROWS = 1 << HALF_W;
  localparam int RAM_ROWS = NUM_BANKS * ROM_ROWS;
  localparam int ROW_W    = $clog2(RAM_ROWS);

  typedef struct packed {
    logic err;
    logic rd;
    logic rd_rom;
    logic word;
    logic odd;
  } pend_t;

  // Input fields
  logic [2:0]  req_type;
  logic [1:0]  bank_mode;
  logic [3:0]  bank;
  logic [15:0] addr;
  logic [15:0] wdata;

  assign req_type  = in_tuser[2:0];
  assign bank_mode = in_tuser[4:3];
  assign bank      = in_tdata[3:0];
  assign addr      = in_tdata[19:4];
  assign wdata     = in_tdata[35:20];

  bmro_pkg::cfg_t cfg_r;
  logic [3:0]     sel_bank_r, sel_bank_nxt;
  logic           clr_active_r;
  logic [ROW_W-1:0] clr_cnt_r;

  logic  p_valid_r;
  pend_t p_r;
  logic [3:0] p_bank_r;
  logic  o_valid_r;
  logic [15:0] o_rdata_r;
  logic  o_err_r;
  logic [3:0] o_bank_r;

  bmro_pkg::cmd_t cmd;
  logic accept;
  logic p_move;

  bmro_decode #(
    .ADDR_BITS(ADDR_BITS),
    .NUM_BANKS(NUM_BANKS)
  ) u_decode (
    .cfg      (cfg_r),
    .cur_bank (sel_bank_r),
    .req_type (req_type),
    .bank_mode(bank_mode),
    .bank     (bank),
    .addr     (addr),
    .cmd      (cmd)
  );

  assign p_move    = p_valid_r && (!o_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!p_valid_r || p_move);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Lane addressing: an odd address puts its first byte in the odd lane, and the
  // second byte of a word in the next row of the even lane.
  logic [HALF_W-1:0]   half_odd, half_even;
  logic [HALF_W+3:0]   row_odd_full, row_even_full;
  logic [ROW_W-1:0]    ram_idx_even, ram_idx_odd;
  logic [HALF_W-1:0]   rom_idx_even, rom_idx_odd;
  logic                we_even, we_odd;
  logic [BW-1:0]       wd_even, wd_odd;
  logic                ram_we_even, ram_we_odd, rom_we_even, rom_we_odd;
  logic [BW-1:0]       ram_wd_even, ram_wd_odd, rom_wd_even, rom_wd_odd;
  logic [BW-1:0]       ram_q_even, ram_q_odd, rom_q_even, rom_q_odd;

  always_comb begin
    half_odd      = addr[ADDR_BITS-1:1];
    half_even     = addr[ADDR_BITS-1:1] + HALF_W'(addr[0]);
    row_odd_full  = {cmd.tgt_bank, half_odd};
    row_even_full = {cmd.tgt_bank, half_even};
    we_even       = !cmd.odd || cmd.word;
    we_odd        = cmd.odd || cmd.word;
    wd_even       = cmd.odd ? wdata[15:8] : wdata[7:0];
    wd_odd        = cmd.odd ? wdata[7:0] : wdata[15:8];

    if (clr_active_r) begin
      ram_idx_even = clr_cnt_r;
      ram_idx_odd  = clr_cnt_r;
      rom_idx_even = clr_cnt_r[HALF_W-1:0];
      rom_idx_odd  = clr_cnt_r[HALF_W-1:0];
      ram_we_even  = 1'b1;
      ram_we_odd   = 1'b1;
      rom_we_even  = 1'b1;
      rom_we_odd   = 1'b1;
      ram_wd_even  = '0;
      ram_wd_odd   = '0;
      rom_wd_even  = '0;
      rom_wd_odd   = '0;
    end else begin
      ram_idx_even = row_even_full[ROW_W-1:0];
      ram_idx_odd  = row_odd_full[ROW_W-1:0];
      rom_idx_even = half_even;
      rom_idx_odd  = half_odd;
      ram_we_even  = accept && cmd.wr_ram && we_even;
      ram_we_odd   = accept && cmd.wr_ram && we_odd;
      rom_we_even  = accept && cmd.wr_rom && we_even;
      rom_we_odd   = accept && cmd.wr_rom && we_odd;
      ram_wd_even  = wd_even & bmro_pkg::BYTE_MASK;
      ram_wd_odd   = wd_odd & bmro_pkg::BYTE_MASK;
      rom_wd_even  = wd_even & bmro_pkg::BYTE_MASK;
      rom_wd_odd   = wd_odd & bmro_pkg::BYTE_MASK;
    end
  end

  bmro_lane_mem #(.DEPTH(RAM_ROWS), .IDX_W(ROW_W)) u_ram_even (
    .clk(clk), .we(ram_we_even), .re(accept), .idx(ram_idx_even),
    .wdata(ram_wd_even), .rdata(ram_q_even)
  );

  bmro_lane_mem #(.DEPTH(RAM_ROWS), .IDX_W(ROW_W)) u_ram_odd (
    .clk(clk), .we(ram_we_odd), .re(accept), .idx(ram_idx_odd),
    .wdata(ram_wd_odd), .rdata(ram_q_odd)
  );

  bmro_lane_mem #(.DEPTH(ROM_ROWS), .IDX_W(HALF_W)) u_rom_even (
    .clk(clk), .we(rom_we_even), .re(accept), .idx(rom_idx_even),
    .wdata(rom_wd_even), .rdata(rom_q_even)
  );

  bmro_lane_mem #(.DEPTH(ROM_ROWS), .IDX_W(HALF_W)) u_rom_odd (
    .clk(clk), .we(rom_we_odd), .re(accept), .idx(rom_idx_odd),
    .wdata(rom_wd_odd), .rdata(rom_q_odd)
  );

  always_comb begin
    sel_bank_nxt = sel_bank_r;
    if (accept && cmd.sel_bank) begin
      sel_bank_nxt = cmd.tgt_bank;
    end
  end

  // Byte-lane reassembly of the read in flight.
  logic [BW-1:0] lane_ev, lane_od;
  logic [15:0]   rd_val;

  always_comb begin
    lane_ev = p_r.rd_rom ? rom_q_even : ram_q_even;
    lane_od = p_r.rd_rom ? rom_q_odd : ram_q_odd;
    if (p_r.odd) begin
      rd_val = {(p_r.word ? lane_ev : 8'h00), lane_od};
    end else begin
      rd_val = {(p_r.word ? lane_od : 8'h00), lane_ev};
    end
    if (!p_r.rd || p_r.err) begin
      rd_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_enabled <= 1'b0;
      cfg_r.rom_start   <= '0;
      cfg_r.rom_size    <= '0;
      cfg_r.main_size   <= 17'h10000;
      cfg_r.bank_count  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmro_pkg::CFG_ROM_ENABLED: cfg_r.rom_enabled <= cfg_data[0];
        bmro_pkg::CFG_ROM_START:   cfg_r.rom_start   <= cfg_data[15:0];
        bmro_pkg::CFG_ROM_SIZE:    cfg_r.rom_size    <= cfg_data;
        bmro_pkg::CFG_MAIN_SIZE:   cfg_r.main_size   <= cfg_data;
        bmro_pkg::CFG_BANK_COUNT:  cfg_r.bank_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      sel_bank_r   <= '0;
      p_valid_r    <= 1'b0;
      o_valid_r    <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + ROW_W'(1);
        if (clr_cnt_r == ROW_W'(RAM_ROWS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      sel_bank_r <= sel_bank_nxt;
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        o_valid_r <= 1'b1;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r.err    <= cmd.err;
      p_r.rd     <= cmd.rd;
      p_r.rd_rom <= cmd.rd_rom;
      p_r.word   <= cmd.word;
      p_r.odd    <= cmd.odd;
      p_bank_r   <= sel_bank_nxt;
    end
    if (p_move) begin
      o_rdata_r <= rd_val;
      o_err_r   <= p_r.err;
      o_bank_r  <= p_bank_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {4'b0000, o_bank_r, o_rdata_r};
  assign out_tuser  = o_err_r;

  // No access may slip in while the clearing pass owns the memory ports.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input accepted during clearing pass");

  // A failed access never reports data.
  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_err_r) |-> (o_rdata_r == 16'h0000))
    else $error("error result with nonzero data");

  // A read in flight must not be lost while the output stalls.
  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && o_valid_r && !out_tready) |=> (p_valid_r && $stable(p_bank_r)))
    else $error("pending read dropped under stall");

  // The current bank always names an existing bank.
  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, sel_bank_r} < 5'(NUM_BANKS)))
    else $error("selected bank out of range");

endmodule

// ----- test/tb_banked_memory_rom_overlay.sv -----
module tb_banked_memory_rom_overlay;

  localparam int ADDR_BITS = 16;
  localparam int NUM_BANKS = 16;
  localparam int unsigned SPAN = 1 << ADDR_BITS;
  localparam int LIMIT = 1_600_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 66;

  // Codes the block must reject.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] rdata;
    logic        err;
    logic [3:0]  bank;
  } mem_result_t;

  typedef enum logic [1:0] {ROW_ACC, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  req;
    logic [1:0]  mode;
    logic [3:0]  bk;
    logic [15:0] addr;
    logic [15:0] wdata;
    mem_result_t typed;
    logic [2:0]  cfg_idx;
    logic [16:0] cfg_val;
  } stim_row_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BURSTY} rdy_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // bank[3:0], addr[19:4], wdata[35:20], zero fill
  logic [4:0]  in_tuser = '0;   // req_type[2:0], bank_mode[4:3]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // rdata[15:0], active_bank[19:16], zero fill
  logic [0:0]  out_tuser;       // error[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  banked_memory_rom_overlay #(
    .ADDR_BITS(ADDR_BITS),
    .NUM_BANKS(NUM_BANKS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the memory contents and registers.
  bit [7:0]    ram_img [0:NUM_BANKS*SPAN-1];
  bit [7:0]    rom_img [0:SPAN-1];
  int unsigned m_sel_bank = 0;
  int unsigned m_rom_en = 0;
  int unsigned m_rom_start = 0;
  int unsigned m_rom_size = 0;
  int unsigned m_main_size = 65536;
  int unsigned m_bank_count = 1;

  mem_result_t expected_results [$];
  stim_row_t   directed_rows [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic [7:0]  rdy_cnt = '0;
  rdy_style_t  rdy_style = RDY_ALWAYS;
  mem_result_t got_word;
  mem_result_t want_word;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("banked_memory_rom_overlay verification failed");
      $finish;
    end
  end

  // The receiver picks a new stall pattern at random whenever the low six bits of its counter read zero.
  always @(posedge clk) begin
    rdy_cnt <= rdy_cnt + 8'd1;
    if (rdy_cnt[5:0] == 6'd0)
      rdy_style <= rdy_style_t'($urandom_range(0, 3));
    case (rdy_style)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_tready <= (rdy_cnt[1:0] == 2'b00);
      default:    out_tready <= (rdy_cnt[3:0] >= 4'd11);
    endcase
  end

  function automatic bit rom_window(int unsigned a, int unsigned last);
    return m_rom_en != 0 && a >= m_rom_start && last < m_rom_start + m_rom_size;
  endfunction

  function automatic int unsigned ram_limit();
    return (m_main_size < SPAN) ? m_main_size : SPAN;
  endfunction

  function automatic int unsigned ram_index(int unsigned b, int unsigned a);
    return ((b % NUM_BANKS) << ADDR_BITS) | (a & (SPAN - 1));
  endfunction

  function automatic logic [15:0] ram_read(int unsigned b, int unsigned a, int unsigned len);
    logic [15:0] v;
    v = {8'h00, ram_img[ram_index(b, a)]};
    if (len == 2)
      v[15:8] = ram_img[ram_index(b, a + 1)];
    return v;
  endfunction

  function automatic void ram_write(int unsigned b, int unsigned a, int unsigned len,
                                    logic [15:0] d);
    ram_img[ram_index(b, a)] = d[7:0];
    if (len == 2)
      ram_img[ram_index(b, a + 1)] = d[15:8];
  endfunction

  // Bank 0 reads: the ROM window wins, then RAM below the limit.
  function automatic bit bank0_read(int unsigned a, int unsigned len, output logic [15:0] v);
    int unsigned last;
    bit err;
    last = a + len - 1;
    v = '0;
    err = 1'b0;
    if (last >= SPAN) begin
      err = 1'b1;
    end else if (rom_window(a, last)) begin
      v[7:0] = rom_img[a];
      if (len == 2)
        v[15:8] = rom_img[last];
    end else if (last < ram_limit()) begin
      v = ram_read(0, a, len);
    end else begin
      err = 1'b1;
    end
    return err;
  endfunction

  function automatic bit read_access(logic [1:0] mode, int unsigned b, int unsigned a,
                                     int unsigned len, output logic [15:0] v);
    int unsigned last;
    bit err;
    last = a + len - 1;
    v = '0;
    err = 1'b0;
    case (mode)
      bmro_pkg::MODE_BANK0: err = bank0_read(a, len, v);
      bmro_pkg::MODE_EXPLICIT: begin
        if (b == 0)
          err = bank0_read(a, len, v);
        else if (b >= m_bank_count || b >= NUM_BANKS || last >= SPAN)
          err = 1'b1;
        else
          v = ram_read(b, a, len);
      end
      bmro_pkg::MODE_CURRENT: begin
        if (m_sel_bank == 0)
          err = bank0_read(a, len, v);
        else if (last >= SPAN)
          err = 1'b1;
        else
          v = ram_read(m_sel_bank, a, len);
      end
      default: err = 1'b1;
    endcase
    return err;
  endfunction

  function automatic bit ram_write_access(logic [1:0] mode, int unsigned b, int unsigned a,
                                          int unsigned len, logic [15:0] d);
    int unsigned last;
    int unsigned tgt;
    bit err;
    last = a + len - 1;
    tgt = 0;
    err = 1'b0;
    if (last >= ram_limit()) begin
      err = 1'b1;
    end else begin
      case (mode)
        bmro_pkg::MODE_BANK0: tgt = 0;
        bmro_pkg::MODE_EXPLICIT: begin
          if (b >= m_bank_count || b >= NUM_BANKS)
            err = 1'b1;
          else
            tgt = b;
        end
        bmro_pkg::MODE_CURRENT: tgt = m_sel_bank;
        default: err = 1'b1;
      endcase
    end
    if (!err)
      ram_write(tgt, a, len, d);
    return err;
  endfunction

  // Debug writes patch the ROM inside its window, else RAM bank 0.
  function automatic bit patch_write(int unsigned a, int unsigned len, logic [15:0] d);
    int unsigned last;
    bit err;
    last = a + len - 1;
    err = 1'b0;
    if (last >= SPAN) begin
      err = 1'b1;
    end else if (rom_window(a, last)) begin
      rom_img[a] = d[7:0];
      if (len == 2)
        rom_img[last] = d[15:8];
    end else if (last < ram_limit()) begin
      ram_write(0, a, len, d);
    end else begin
      err = 1'b1;
    end
    return err;
  endfunction

  function automatic mem_result_t predict_access(logic [2:0] req, logic [1:0] mode,
                                                 logic [3:0] bk, logic [15:0] a,
                                                 logic [15:0] d);
    mem_result_t r;
    logic [15:0] v;
    bit err;
    v = '0;
    case (req)
      bmro_pkg::REQ_RD_BYTE:  err = read_access(mode, 32'(bk), 32'(a), 1, v);
      bmro_pkg::REQ_RD_WORD:  err = read_access(mode, 32'(bk), 32'(a), 2, v);
      bmro_pkg::REQ_WR_BYTE:  err = ram_write_access(mode, 32'(bk), 32'(a), 1, d);
      bmro_pkg::REQ_WR_WORD:  err = ram_write_access(mode, 32'(bk), 32'(a), 2, d);
      bmro_pkg::REQ_DBG_BYTE: err = patch_write(32'(a), 1, d);
      bmro_pkg::REQ_DBG_WORD: err = patch_write(32'(a), 2, d);
      bmro_pkg::REQ_SEL_BANK: begin
        err = !(bk < m_bank_count && bk < NUM_BANKS);
        if (!err)
          m_sel_bank = 32'(bk);
      end
      default: err = 1'b1;
    endcase
    if (err)
      v = '0;
    r.rdata = v;
    r.err = err;
    r.bank = m_sel_bank[3:0];
    return r;
  endfunction

  function automatic void add_acc(logic [2:0] req, logic [1:0] mode, logic [3:0] bk,
                                  logic [15:0] a, logic [15:0] d);
    stim_row_t row;
    row = '{ROW_ACC, req, mode, bk, a, d, '0, '0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic [2:0] req, logic [1:0] mode, logic [3:0] bk,
                                    logic [15:0] a, logic [15:0] d, logic [15:0] rd,
                                    logic er, logic [3:0] eb);
    stim_row_t row;
    row = '{ROW_TYPED, req, mode, bk, a, d, '{rd, er, eb}, '0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [16:0] val);
    stim_row_t row;
    row = '{ROW_CFG, '0, '0, '0, '0, '0, '0, idx, val};
    directed_rows.push_back(row);
  endfunction

  function automatic void note_mismatch(string what, mem_result_t want, mem_result_t got);
    if (mismatches < 10)
      $display("mismatch (%s): expected rdata %h err %b bank %0d, got rdata %h err %b bank %0d",
               what, want.rdata, want.err, want.bank, got.rdata, got.err, got.bank);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = '{out_tdata[15:0], out_tuser[0], out_tdata[19:16]};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected word", '0, got_word);
      end else begin
        want_word = expected_results.pop_front();
        if (got_word.rdata !== want_word.rdata)
          note_mismatch("rdata", want_word, got_word);
        else if (got_word.err !== want_word.err)
          note_mismatch("error", want_word, got_word);
        else if (got_word.bank !== want_word.bank)
          note_mismatch("active_bank", want_word, got_word);
      end
    end
  end

  task automatic send_access(input logic [2:0] req, input logic [1:0] mode,
                             input logic [3:0] bk, input logic [15:0] a, input logic [15:0] d,
                             input bit use_typed, input mem_result_t typed);
    mem_result_t pred;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, d, a, bk};
    in_tuser <= {mode, req};
    do @(posedge clk); while (!in_tready);
    pred = predict_access(req, mode, bk, a, d);
    expected_results.push_back(use_typed ? typed : pred);
  endtask

  // Hold the sender until every outstanding word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bmro_pkg::CFG_ROM_ENABLED: m_rom_en = 32'(val[0]);
      bmro_pkg::CFG_ROM_START:   m_rom_start = 32'(val[15:0]);
      bmro_pkg::CFG_ROM_SIZE:    m_rom_size = 32'(val);
      bmro_pkg::CFG_MAIN_SIZE:   m_main_size = 32'(val);
      bmro_pkg::CFG_BANK_COUNT:  m_bank_count = 32'(val[3:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [2:0]  req;
    logic [1:0]  mode;
    logic [3:0]  bk;
    logic [15:0] addr;
    logic [15:0] wdata;
    int unsigned a32;
    int          pick;
    logic        r_en;
    logic [16:0] r_start;
    logic [16:0] r_size;
    logic [16:0] r_main;
    logic [16:0] r_count;

    // Reset configuration: no ROM, full RAM span, one bank.
    add_typed(bmro_pkg::REQ_RD_BYTE, bmro_pkg::MODE_BANK0, 4'd0, 16'h0000, 16'h0000,
              16'h0000, 1'b0, 4'd0);
    add_typed(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'hFFFF, 16'h0000,
              16'h0000, 1'b1, 4'd0);
    add_typed(bmro_pkg::REQ_WR_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'h1234, 16'hBEEF,
              16'h0000, 1'b0, 4'd0);
    add_typed(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'h1234, 16'h0000,
              16'hBEEF, 1'b0, 4'd0);
    add_typed(bmro_pkg::REQ_RD_BYTE, bmro_pkg::MODE_CURRENT, 4'd0, 16'h1235, 16'h0000,
              16'h00BE, 1'b0, 4'd0);
    add_typed(bmro_pkg::REQ_SEL_BANK, bmro_pkg::MODE_BANK0, 4'd1, 16'h0000, 16'h0000,
              16'h0000, 1'b1, 4'd0);
    add_typed(bmro_pkg::REQ_RD_BYTE, MODE_UNUSED, 4'd0, 16'h1234, 16'h0000,
              16'h0000, 1'b1, 4'd0);
    add_typed(REQ_UNUSED, bmro_pkg::MODE_BANK0, 4'd0, 16'h0000, 16'hFFFF,
              16'h0000, 1'b1, 4'd0);
    add_typed(bmro_pkg::REQ_WR_BYTE, bmro_pkg::MODE_EXPLICIT, 4'd1, 16'h0000, 16'h00A5,
              16'h0000, 1'b1, 4'd0);
    add_typed(bmro_pkg::REQ_WR_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'hFFFF, 16'h1111,
              16'h0000, 1'b1, 4'd0);
    // ROM over the top quarter, RAM limited to the lower half, 15 banks.
    add_cfg(bmro_pkg::CFG_BANK_COUNT, 17'd15);
    add_cfg(bmro_pkg::CFG_ROM_START, 17'h0C000);
    add_cfg(bmro_pkg::CFG_ROM_SIZE, 17'h04000);
    add_cfg(bmro_pkg::CFG_ROM_ENABLED, 17'd1);
    add_cfg(bmro_pkg::CFG_MAIN_SIZE, 17'h08000);
    add_typed(bmro_pkg::REQ_DBG_WORD, MODE_UNUSED, 4'd0, 16'hC000, 16'h55AA,
              16'h0000, 1'b0, 4'd0);
    add_typed(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'hC000, 16'h0000,
              16'h55AA, 1'b0, 4'd0);
    add_acc(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_EXPLICIT, 4'd0, 16'hC000, 16'h0000);
    add_acc(bmro_pkg::REQ_DBG_BYTE, bmro_pkg::MODE_BANK0, 4'd0, 16'h0010, 16'hABFF);
    add_acc(bmro_pkg::REQ_RD_BYTE, bmro_pkg::MODE_BANK0, 4'd0, 16'h0010, 16'h0000);
    add_typed(bmro_pkg::REQ_WR_BYTE, bmro_pkg::MODE_BANK0, 4'd0, 16'h8000, 16'h0001,
              16'h0000, 1'b1, 4'd0);
    add_typed(bmro_pkg::REQ_SEL_BANK, MODE_UNUSED, 4'd14, 16'hFFFF, 16'hFFFF,
              16'h0000, 1'b0, 4'd14);
    add_acc(bmro_pkg::REQ_WR_WORD, bmro_pkg::MODE_CURRENT, 4'd0, 16'h7FFE, 16'h1357);
    add_acc(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_EXPLICIT, 4'd14, 16'h7FFE, 16'h0000);
    add_acc(bmro_pkg::REQ_RD_BYTE, bmro_pkg::MODE_EXPLICIT, 4'd14, 16'hFFFE, 16'h0000);
    add_typed(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_CURRENT, 4'd0, 16'hFFFF, 16'h0000,
              16'h0000, 1'b1, 4'd14);
    add_typed(bmro_pkg::REQ_SEL_BANK, bmro_pkg::MODE_BANK0, 4'd15, 16'h0000, 16'h0000,
              16'h0000, 1'b1, 4'd14);
    add_acc(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'hBFFF, 16'h0000);
    add_acc(bmro_pkg::REQ_DBG_WORD, bmro_pkg::MODE_BANK0, 4'd0, 16'hFFFF, 16'h2222);
    // The current bank stays usable after bank_count drops below it.
    add_cfg(bmro_pkg::CFG_BANK_COUNT, 17'd1);
    add_acc(bmro_pkg::REQ_RD_WORD, bmro_pkg::MODE_CURRENT, 4'd0, 16'h7FFE, 16'h0000);
    add_acc(bmro_pkg::REQ_WR_BYTE, bmro_pkg::MODE_EXPLICIT, 4'd15, 16'h0000, 16'h0077);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_cfg_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        send_access(directed_rows[i].req, directed_rows[i].mode, directed_rows[i].bk,
                    directed_rows[i].addr, directed_rows[i].wdata,
                    directed_rows[i].kind == ROW_TYPED, directed_rows[i].typed);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          r_en = 1'b1; r_start = 17'h00000; r_size = 17'h10000;
          r_main = 17'h10000; r_count = 17'd15;
        end
        1: begin
          r_en = 1'b0; r_start = 17'h0FFFF; r_size = 17'h00000;
          r_main = 17'h00000; r_count = 17'd0;
        end
        2: begin
          r_en = 1'b1; r_start = 17'h0FFFF; r_size = 17'h00001;
          r_main = 17'h0FFFF; r_count = 17'd4;
        end
        3: begin
          r_en = 1'b1; r_start = 17'h08000; r_size = 17'h00100;
          r_main = 17'h09000; r_count = 17'd8;
        end
        default: begin
          r_en = 1'($urandom_range(0, 1));
          r_start = 17'($urandom_range(0, 65535));
          r_size = 17'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 64)
                                                   : $urandom_range(0, 65536));
          r_main = 17'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                                   : $urandom_range(0, 65536));
          r_count = 17'($urandom_range(0, 15));
        end
      endcase
      drain_results();
      write_cfg_reg(bmro_pkg::CFG_ROM_ENABLED, {16'h0000, r_en});
      write_cfg_reg(bmro_pkg::CFG_ROM_START, r_start);
      write_cfg_reg(bmro_pkg::CFG_ROM_SIZE, r_size);
      write_cfg_reg(bmro_pkg::CFG_MAIN_SIZE, r_main);
      write_cfg_reg(bmro_pkg::CFG_BANK_COUNT, r_count);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2)
          drain_results();
        pick = $urandom_range(0, 31);
        req = (pick == 31) ? REQ_UNUSED : 3'(pick % 7);
        mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        if (m_bank_count != 0 && $urandom_range(0, 3) != 0)
          bk = 4'($urandom_range(0, m_bank_count - 1));
        else
          bk = 4'($urandom_range(0, 15));
        // Addresses cluster around the window and limit edges so reads find written data.
        case ($urandom_range(0, 5))
          0: a32 = $urandom_range(0, 63);
          1: a32 = m_rom_start + $urandom_range(0, 31);
          2: a32 = m_rom_start + m_rom_size - 4 + $urandom_range(0, 7);
          3: a32 = m_main_size - 4 + $urandom_range(0, 7);
          4: a32 = 32'hFFFF - $urandom_range(0, 3);
          default: a32 = $urandom_range(0, 65535);
        endcase
        addr = a32[15:0];
        wdata = 16'($urandom_range(0, 65535));
        send_access(req, mode, bk, addr, wdata, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("banked_memory_rom_overlay verification clean");
    else
      $display("banked_memory_rom_overlay verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bmro_pkg.sv
design/bmro_lane_mem.sv
design/bmro_decode.sv
design/banked_memory_rom_overlay.sv
test/tb_banked_memory_rom_overlay.sv
